@@ src/ulsd_pkg.sv @@
// ulsd_pkg: constants and types shared by the ULEB128 string deframer.
// No dependencies; used by ulsd_group_merge and uleb128_string_deframer_unit.

package ulsd_pkg;

   localparam logic [7:0] GROUP_MASK = 8'h7f;
   localparam logic [7:0] MORE_BIT   = 8'h80;
   localparam int unsigned GROUP_BITS = 7;

   // shift position of the next length group, saturating
   localparam int unsigned SHIFT_W = 7;
   localparam logic [SHIFT_W-1:0] SHIFT_CAP = 7'd70;

   localparam int unsigned STR_LEN_W = 32;

   typedef struct packed {
      logic overflow_hit;   // this group had set bits beyond the accumulator
      logic more;           // another length byte follows
   } group_status_type;

endpackage

@@ src/ulsd_group_merge.sv @@
// ulsd_group_merge: folds one ULEB128 length byte into the length accumulator.
// Depends on ulsd_pkg.

module ulsd_group_merge #(
   parameter int LENGTH_BITS = 32
) (
   input  logic [7:0]                      byte_in,
   input  logic [ulsd_pkg::SHIFT_W-1:0]    shift_pos,
   input  logic [LENGTH_BITS-1:0]          accum,
   output logic [LENGTH_BITS-1:0]          accum_next,
   output logic [ulsd_pkg::SHIFT_W-1:0]    shift_next,
   output ulsd_pkg::group_status_type      status
);

   localparam int unsigned WIDE_W = LENGTH_BITS + ulsd_pkg::GROUP_BITS;
   localparam logic [ulsd_pkg::SHIFT_W-1:0] LEN_POS = ulsd_pkg::SHIFT_W'(LENGTH_BITS);
   localparam logic [ulsd_pkg::SHIFT_W-1:0] STEP = ulsd_pkg::SHIFT_W'(ulsd_pkg::GROUP_BITS);

   logic [6:0]                   group;
   logic [WIDE_W-1:0]            shifted;
   logic [ulsd_pkg::SHIFT_W:0]   shift_sum;

   assign group   = byte_in[6:0] & ulsd_pkg::GROUP_MASK[6:0];
   assign shifted = WIDE_W'(group) << shift_pos;

   // groups wholly above the accumulator shift out entirely and only flag
   assign accum_next = accum | shifted[LENGTH_BITS-1:0];

   always_comb begin
      status.more         = (byte_in & ulsd_pkg::MORE_BIT) != 8'h00;
      status.overflow_hit = (group != 7'd0) &&
                            ((shift_pos >= LEN_POS) ||
                             (shifted[WIDE_W-1:LENGTH_BITS] != '0));
   end

   assign shift_sum  = {1'b0, shift_pos} + {1'b0, STEP};
   assign shift_next = (shift_sum > {1'b0, ulsd_pkg::SHIFT_CAP}) ?
                       ulsd_pkg::SHIFT_CAP : shift_sum[ulsd_pkg::SHIFT_W-1:0];

endmodule

@@ src/uleb128_string_deframer_unit.sv @@
// ULEB128 length-prefixed string deframer, one byte per request: decodes a
// length prefix, then passes the payload bytes out with a last mark. A byte
// goes through the input register, then the result register; a new byte can
// be taken every cycle while the result is not held back by rsp_ready. Length
// bytes produce no result; a zero length produces one empty result. Length
// bits at LENGTH_BITS and above are dropped and flagged on all results of
// that string. Depends on ulsd_pkg and ulsd_group_merge.

module uleb128_string_deframer_unit #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   output logic        rsp_empty_res,
   output logic        rsp_length_overflow,
   output logic [ulsd_pkg::STR_LEN_W-1:0] rsp_string_length
);

   // input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   // deframer state
   logic                         in_payload_ff, in_payload_in;
   logic [LENGTH_BITS-1:0]       length_accum_ff, length_accum_in;
   logic [ulsd_pkg::SHIFT_W-1:0] shift_pos_ff, shift_pos_in;
   logic [LENGTH_BITS-1:0]       bytes_left_ff, bytes_left_in;
   logic [LENGTH_BITS-1:0]       current_length_ff, current_length_in;
   logic                         overflow_seen_ff, overflow_seen_in;

   // result register
   logic                         rsp_valid_ff;
   logic [7:0]                   data_byte_ff, data_byte_in;
   logic                         last_ff, last_in;
   logic                         empty_ff, empty_in;
   logic                         ovf_ff, ovf_in;
   logic [ulsd_pkg::STR_LEN_W-1:0] str_len_ff, str_len_in;
   logic                         produce;

   logic                         advance;
   logic [LENGTH_BITS-1:0]       accum_merged;
   logic [ulsd_pkg::SHIFT_W-1:0] shift_merged;
   ulsd_pkg::group_status_type   grp;
   logic                         ovf_merged;
   logic [ulsd_pkg::STR_LEN_W-1:0] cur_len32;

   assign advance   = in_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   ulsd_group_merge #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_merge (
      .byte_in    (in_byte_ff),
      .shift_pos  (shift_pos_ff),
      .accum      (length_accum_ff),
      .accum_next (accum_merged),
      .shift_next (shift_merged),
      .status     (grp)
   );

   assign ovf_merged = overflow_seen_ff || grp.overflow_hit;

   generate
      if (LENGTH_BITS >= ulsd_pkg::STR_LEN_W) begin : g_len_wide
         assign cur_len32 = current_length_ff[ulsd_pkg::STR_LEN_W-1:0];
      end else begin : g_len_narrow
         assign cur_len32 = ulsd_pkg::STR_LEN_W'(current_length_ff);
      end
   endgenerate

   always_comb begin
      in_payload_in     = in_payload_ff;
      length_accum_in   = length_accum_ff;
      shift_pos_in      = shift_pos_ff;
      bytes_left_in     = bytes_left_ff;
      current_length_in = current_length_ff;
      overflow_seen_in  = overflow_seen_ff;
      produce           = 1'b0;
      data_byte_in      = in_byte_ff;
      last_in           = 1'b0;
      empty_in          = 1'b0;
      ovf_in            = overflow_seen_ff;
      str_len_in        = cur_len32;

      if (in_payload_ff) begin
         produce       = 1'b1;
         last_in       = (bytes_left_ff == LENGTH_BITS'(1));
         bytes_left_in = bytes_left_ff - LENGTH_BITS'(1);
         if (last_in) begin
            in_payload_in    = 1'b0;
            length_accum_in  = '0;
            shift_pos_in     = '0;
            overflow_seen_in = 1'b0;
         end
      end else begin
         length_accum_in  = accum_merged;
         shift_pos_in     = shift_merged;
         overflow_seen_in = ovf_merged;
         if (!grp.more) begin
            current_length_in = accum_merged;
            if (accum_merged == '0) begin
               // zero length: single empty result, then a fresh length
               produce          = 1'b1;
               data_byte_in     = 8'h00;
               last_in          = 1'b1;
               empty_in         = 1'b1;
               ovf_in           = ovf_merged;
               str_len_in       = '0;
               length_accum_in  = '0;
               shift_pos_in     = '0;
               bytes_left_in    = '0;
               overflow_seen_in = 1'b0;
            end else begin
               bytes_left_in = accum_merged;
               in_payload_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         in_payload_ff     <= 1'b0;
         length_accum_ff   <= '0;
         shift_pos_ff      <= '0;
         bytes_left_ff     <= '0;
         current_length_ff <= '0;
         overflow_seen_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            in_payload_ff     <= in_payload_in;
            length_accum_ff   <= length_accum_in;
            shift_pos_ff      <= shift_pos_in;
            bytes_left_ff     <= bytes_left_in;
            current_length_ff <= current_length_in;
            overflow_seen_ff  <= overflow_seen_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_byte_in;
      end
      if (advance && produce) begin
         data_byte_ff <= data_byte_in;
         last_ff      <= last_in;
         empty_ff     <= empty_in;
         ovf_ff       <= ovf_in;
         str_len_ff   <= str_len_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_byte       = data_byte_ff;
   assign rsp_last            = last_ff;
   assign rsp_empty_res       = empty_ff;
   assign rsp_length_overflow = ovf_ff;
   assign rsp_string_length   = str_len_ff;

`ifndef SYNTHESIS
   // an empty request result always closes the string with zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_last && rsp_data_byte == 8'h00
                                        && rsp_string_length == '0))
      else $error("empty result without last or with nonzero data");

   // while passing payload there is always at least one byte outstanding
   assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (bytes_left_ff != '0))
      else $error("payload state with no bytes left");

   // a result taken with no new one produced leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !(advance && produce)) |=> !rsp_valid)
      else $error("result repeated after hand-off");
`endif

endmodule
